// File: hw/rtl/tc3_pkg.sv
// ----------------------------------------------------------------------------
// tc3_pkg
// Shared constants, register map and channel request/response types for the
// three-channel timer/counter.
// ----------------------------------------------------------------------------
package tc3_pkg;

	localparam int NUM_CHANNELS = 3;

	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 9;
	localparam int OFF_W   = 6;
	localparam int CH_W    = ADDR_W - OFF_W;
	localparam int CNT_W   = 16;
	localparam int FLAG_W  = 8;
	localparam int REQ_W   = 2;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

	// per-channel register offsets
	localparam logic [OFF_W-1:0] OFF_CCR = 6'h00;
	localparam logic [OFF_W-1:0] OFF_CMR = 6'h04;
	localparam logic [OFF_W-1:0] OFF_CV  = 6'h10;
	localparam logic [OFF_W-1:0] OFF_RA  = 6'h14;
	localparam logic [OFF_W-1:0] OFF_RB  = 6'h18;
	localparam logic [OFF_W-1:0] OFF_RC  = 6'h1C;
	localparam logic [OFF_W-1:0] OFF_SR  = 6'h20;
	localparam logic [OFF_W-1:0] OFF_IER = 6'h24;
	localparam logic [OFF_W-1:0] OFF_IDR = 6'h28;
	localparam logic [OFF_W-1:0] OFF_IMR = 6'h2C;

	// bit positions and values
	localparam int CLK_RUN_BIT  = 16;
	localparam int WAVE_BIT     = 15;
	localparam int WAVSEL_LO    = 13;
	localparam int WAVSEL_HI    = 14;
	localparam int CCR_EN_BIT   = 0;
	localparam int CCR_DIS_BIT  = 1;
	localparam logic [1:0]        WAVSEL_UP_RC   = 2'd2;
	localparam logic [CNT_W-1:0]  COUNT_MAX      = 16'hFFFF;
	localparam logic [DATA_W-1:0] WRITE_ONLY_VAL = 32'hDEADBEEF;

	typedef struct packed {
		logic              rd_en;   // bus read to this channel
		logic              wr_en;   // bus write to this channel
		logic              tick_en; // counter tick, all channels
		logic [OFF_W-1:0]  off;
		logic [DATA_W-1:0] wdata;
	} chan_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata; // zero unless rd_en
		logic              bad;
		logic              fired; // reload on this tick
		logic              sr_rd; // status read, flags cleared
	} chan_rsp_t;

endpackage

// File: hw/rtl/three_channel_timer_counter.sv
// ----------------------------------------------------------------------------
// three_channel_timer_counter
// Three 16-bit timer channels behind a 32-bit register bus, with a shared
// tick request and a single interrupt line.
// ----------------------------------------------------------------------------
//
//   channel | beat fields                       | handshake
//   --------+-----------------------------------+----------------------
//   req     | req_type, address, write_data     | req_valid / req_stall
//   rsp     | read_data, irq, bad_access        | rsp_valid / rsp_stall
//
// One rsp beat per req beat, in order. A req beat is registered, executed
// against the channel registers when the output register can take it, and
// its result lands there; one beat per cycle sustained while rsp_stall is low.
// The input stage stalls only when the output register holds an untaken beat.
// arst_n resets control and channel regs: counters, periods to 0xffff, rest 0.
//
module three_channel_timer_counter
	import tc3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [DATA_W-1:0] read_data,
	output logic              irq,
	output logic              bad_access
);

	// input register
	logic              v_s1;
	logic [REQ_W-1:0]  type_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1;

	logic              irq_level_q;
	logic              advance;   // output register can take a beat
	logic              exec;      // stage-1 beat executes this cycle
	logic              is_rd, is_wr, is_tick;
	logic [CH_W-1:0]   ch;
	logic              in_range;

	chan_req_t         creq [NUM_CHANNELS];
	chan_rsp_t         crsp [NUM_CHANNELS];

	logic [DATA_W-1:0] rdata_n;
	logic              bad_n, fired_n, sr_rd_n, irq_n;

	assign advance   = !rsp_valid || !rsp_stall;
	assign exec      = v_s1 && advance;
	assign req_stall = v_s1 && !advance;

	// stage 1 loads whenever it is empty or its beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (!req_stall)
			v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			type_s1  <= req_type;
			addr_s1  <= address;
			wdata_s1 <= write_data;
		end
	end

	// decode
	assign ch       = addr_s1[ADDR_W-1:OFF_W];
	assign in_range = (ch < CH_W'(NUM_CHANNELS));

	always_comb begin
		is_rd   = 1'b0;
		is_wr   = 1'b0;
		is_tick = 1'b0;
		case (type_s1)
			REQ_READ:  is_rd   = exec;
			REQ_WRITE: is_wr   = exec;
			REQ_TICK:  is_tick = exec;
			default: ;  // unknown kind: no effect
		endcase
	end

	for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
		assign creq[g].rd_en   = is_rd && in_range && ch == CH_W'(g);
		assign creq[g].wr_en   = is_wr && in_range && ch == CH_W'(g);
		assign creq[g].tick_en = is_tick;
		assign creq[g].off     = addr_s1[OFF_W-1:0];
		assign creq[g].wdata   = wdata_s1;

		tc3_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (creq[g]),
			.rsp    (crsp[g])
		);
	end

	// merge channel responses; only the addressed channel drives nonzero data
	always_comb begin
		rdata_n = '0;
		bad_n   = is_rd && !in_range;
		fired_n = 1'b0;
		sr_rd_n = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			rdata_n = rdata_n | crsp[i].rdata;
			bad_n   = bad_n | crsp[i].bad;
			fired_n = fired_n | crsp[i].fired;
			sr_rd_n = sr_rd_n | crsp[i].sr_rd;
		end
	end

	// line follows the last channel to touch it; a status read of any channel lowers it
	always_comb begin
		irq_n = irq_level_q;
		if (fired_n)
			irq_n = 1'b1;
		else if (sr_rd_n)
			irq_n = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_level_q <= 1'b0;
			rsp_valid   <= 1'b0;
		end else begin
			if (exec)
				irq_level_q <= irq_n;
			if (advance)
				rsp_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			read_data  <= rdata_n;
			irq        <= irq_n;
			bad_access <= bad_n;
		end
	end

`ifndef SYNTH
	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bad_access |-> read_data == '0)
		else $error("bad access with nonzero read data");

	a_fire_raises_irq: assert property (@(posedge clk) disable iff (!arst_n)
		exec && fired_n |=> irq_level_q && irq)
		else $error("channel reload did not raise irq");

	a_sr_read_lowers_irq: assert property (@(posedge clk) disable iff (!arst_n)
		exec && sr_rd_n |=> !irq_level_q)
		else $error("status read left irq high");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !v_s1 |=> !rsp_valid)
		else $error("result beat appeared with no item in flight");

	a_one_channel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({is_rd, is_wr, is_tick}) && !(sr_rd_n && fired_n))
		else $error("conflicting request decode");
`endif

endmodule

// File: hw/rtl/tc3_chan.sv
// ----------------------------------------------------------------------------
// tc3_chan
// One timer channel: register file, down counter and read mux.
// ----------------------------------------------------------------------------
module tc3_chan
	import tc3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  chan_req_t req,
	output chan_rsp_t rsp
);

	logic [DATA_W-1:0] mode_q, ra_q, rb_q, rc_q, status_q, imr_q;
	logic [CNT_W-1:0]  period_q, remain_q;
	logic              running;
	logic              up_rc;
	logic [CNT_W-1:0]  top;
	logic [CNT_W-1:0]  cv;
	logic              reload;

	assign running = status_q[CLK_RUN_BIT];
	assign up_rc   = (mode_q[WAVSEL_HI:WAVSEL_LO] == WAVSEL_UP_RC);
	assign top     = up_rc ? rc_q[CNT_W-1:0] : COUNT_MAX;
	assign cv      = top - remain_q;  // wraps at 16 bits
	assign reload  = (remain_q <= CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			ra_q     <= '0;
			rb_q     <= '0;
			rc_q     <= '0;
			status_q <= '0;
			imr_q    <= '0;
			period_q <= COUNT_MAX;
			remain_q <= COUNT_MAX;
		end else if (req.tick_en) begin
			if (running) begin
				if (reload) begin
					remain_q    <= period_q;
					status_q[0] <= 1'b1;
				end else begin
					remain_q <= remain_q - CNT_W'(1);
				end
			end
		end else if (req.wr_en) begin
			case (req.off)
				OFF_CCR: begin
					if (req.wdata[CCR_DIS_BIT])
						status_q[CLK_RUN_BIT] <= 1'b0;
					else if (req.wdata[CCR_EN_BIT])
						status_q[CLK_RUN_BIT] <= 1'b1;
				end
				OFF_CMR: begin
					mode_q <= req.wdata;
					if (req.wdata[WAVE_BIT] &&
					    req.wdata[WAVSEL_HI:WAVSEL_LO] == WAVSEL_UP_RC)
						period_q <= rc_q[CNT_W-1:0];
				end
				OFF_RA:  ra_q <= req.wdata;
				OFF_RB:  rb_q <= req.wdata;
				OFF_RC: begin
					rc_q <= req.wdata;
					if (up_rc)
						period_q <= req.wdata[CNT_W-1:0];
				end
				OFF_IER: imr_q <= imr_q | req.wdata;
				OFF_IDR: imr_q <= imr_q & ~req.wdata;
				default: ;
			endcase
		end else if (req.rd_en && req.off == OFF_SR) begin
			status_q[FLAG_W-1:0] <= '0;
		end
	end

	always_comb begin
		rsp = '0;
		rsp.fired = req.tick_en && running && reload;
		if (req.wr_en && req.off == OFF_CMR)
			rsp.bad = !req.wdata[WAVE_BIT];
		if (req.rd_en) begin
			case (req.off)
				OFF_CCR, OFF_IER, OFF_IDR: rsp.rdata = WRITE_ONLY_VAL;
				OFF_CMR: rsp.rdata = mode_q;
				OFF_CV:  rsp.rdata = running ? DATA_W'(cv) : '0;
				OFF_RA:  rsp.rdata = ra_q;
				OFF_RB:  rsp.rdata = rb_q;
				OFF_RC:  rsp.rdata = rc_q;
				OFF_SR: begin
					rsp.rdata = status_q;
					rsp.sr_rd = 1'b1;
				end
				OFF_IMR: rsp.rdata = imr_q;
				default: rsp.bad = 1'b1;
			endcase
		end
	end

endmodule

// File: bench/tc3_checker.sv
// ----------------------------------------------------------------------------
// tc3_checker
// Watches the req and rsp channels of the timer/counter. Every accepted req
// beat runs through a register-level prediction of the three channels, and the
// expected rsp beat is queued. Every accepted rsp beat is compared with the
// oldest queued one, field by field.
// ----------------------------------------------------------------------------
module tc3_checker
	import tc3_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ADDR_W-1:0] address,
	input  logic [DATA_W-1:0] write_data,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic [DATA_W-1:0] read_data,
	input  logic              irq,
	input  logic              bad_access,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              irq;
		logic              bad;
	} beat_result_t;

	// predicted register file
	logic [DATA_W-1:0] cmr    [NUM_CHANNELS];
	logic [DATA_W-1:0] ra     [NUM_CHANNELS];
	logic [DATA_W-1:0] rb     [NUM_CHANNELS];
	logic [DATA_W-1:0] rc     [NUM_CHANNELS];
	logic [DATA_W-1:0] sr     [NUM_CHANNELS];
	logic [DATA_W-1:0] imr    [NUM_CHANNELS];
	logic [CNT_W-1:0]  period [NUM_CHANNELS];
	logic [CNT_W-1:0]  remain [NUM_CHANNELS];
	logic              irq_line;

	beat_result_t expected_rsp [$];
	beat_result_t want;
	int           mismatches = 0;

	assign fail_count = mismatches;

	function automatic logic up_to_rc(int ch);
		return cmr[ch][WAVSEL_HI:WAVSEL_LO] == WAVSEL_UP_RC;
	endfunction

	// Applies one req beat to the predicted registers, returns its rsp beat.
	function automatic beat_result_t apply_beat(logic [REQ_W-1:0] kind,
			logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		beat_result_t     r;
		int               ch;
		logic [OFF_W-1:0] off;
		logic [CNT_W-1:0] top;
		r   = '0;
		ch  = int'(addr[ADDR_W-1:OFF_W]);
		off = addr[OFF_W-1:0];
		case (kind)
			REQ_READ: begin
				if (ch >= NUM_CHANNELS) begin
					r.bad = 1'b1;
				end else begin
					case (off)
						OFF_CCR, OFF_IER, OFF_IDR: r.rdata = WRITE_ONLY_VAL;
						OFF_CMR: r.rdata = cmr[ch];
						OFF_CV: begin
							if (sr[ch][CLK_RUN_BIT]) begin
								top = up_to_rc(ch) ? rc[ch][CNT_W-1:0] : COUNT_MAX;
								r.rdata = {{(DATA_W-CNT_W){1'b0}}, top - remain[ch]};
							end
						end
						OFF_RA:  r.rdata = ra[ch];
						OFF_RB:  r.rdata = rb[ch];
						OFF_RC:  r.rdata = rc[ch];
						OFF_SR: begin
							r.rdata = sr[ch];
							sr[ch][FLAG_W-1:0] = '0;
							irq_line = 1'b0;
						end
						OFF_IMR: r.rdata = imr[ch];
						default: r.bad = 1'b1;
					endcase
				end
			end
			REQ_WRITE: begin
				if (ch < NUM_CHANNELS) begin
					case (off)
						OFF_CCR: begin
							if (data[CCR_EN_BIT] && !data[CCR_DIS_BIT])
								sr[ch][CLK_RUN_BIT] = 1'b1;
							if (data[CCR_DIS_BIT])
								sr[ch][CLK_RUN_BIT] = 1'b0;
						end
						OFF_CMR: begin
							cmr[ch] = data;
							if (!data[WAVE_BIT])
								r.bad = 1'b1;
							else if (up_to_rc(ch))
								period[ch] = rc[ch][CNT_W-1:0];
						end
						OFF_RA: ra[ch] = data;
						OFF_RB: rb[ch] = data;
						OFF_RC: begin
							rc[ch] = data;
							if (up_to_rc(ch))
								period[ch] = data[CNT_W-1:0];
						end
						OFF_IER: imr[ch] = imr[ch] | data;
						OFF_IDR: imr[ch] = imr[ch] & ~data;
						default: ;
					endcase
				end
			end
			REQ_TICK: begin
				for (int c = 0; c < NUM_CHANNELS; c++) begin
					if (sr[c][CLK_RUN_BIT]) begin
						if (remain[c] <= 1) begin
							remain[c] = period[c];
							sr[c][0]  = 1'b1;
							irq_line  = 1'b1;
						end else begin
							remain[c] = remain[c] - 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		r.irq = irq_line;
		return r;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
			logic [DATA_W-1:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("tc3_checker: %0t %s expected %h got %h", $time, name, exp_v,
					got_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				cmr[c]    = '0;
				ra[c]     = '0;
				rb[c]     = '0;
				rc[c]     = '0;
				sr[c]     = '0;
				imr[c]    = '0;
				period[c] = COUNT_MAX;
				remain[c] = COUNT_MAX;
			end
			irq_line = 1'b0;
			expected_rsp.delete();
			pending <= 0;
		end else begin
			// rsp first: a beat can never come back on the edge it went in
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tc3_checker: %0t rsp beat with nothing expected", $time);
				end else begin
					want = expected_rsp.pop_front();
					check_field("read_data", want.rdata, read_data);
					check_field("irq", DATA_W'(want.irq), DATA_W'(irq));
					check_field("bad_access", DATA_W'(want.bad), DATA_W'(bad_access));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_beat(req_type, address, write_data));
			pending <= expected_rsp.size();
		end
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives bus reads, bus writes and counter ticks into the three-channel
// timer/counter and lets tc3_checker predict and compare every rsp beat.
// A short directed run covers register extremes and corner cases, then every
// channel is started with a short period, then random traffic.
// ----------------------------------------------------------------------------
module testbench;
	import tc3_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	logic [REQ_W-1:0]  req_type;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic              rsp_valid;
	logic              rsp_stall;
	logic [DATA_W-1:0] read_data;
	logic              irq;
	logic              bad_access;

	int fail_count;
	int pending;

	// knobs shared between the sender and the receiver
	bit tx_gaps      = 1'b1; // sender may drop valid for a burst
	bit rx_gaps      = 1'b1; // receiver may stall for a burst
	bit hold_off_now = 1'b0; // receiver: one long stall, please

	localparam int NUM_RANDOM = 1800;
	localparam int HOLD_CYCLES = 80;

	// type 3 is not a defined request, the block must shrug it off
	localparam logic [REQ_W-1:0] REQ_UNDEF = 2'd3;

	// mode word: waveform mode, count up to RC
	localparam logic [DATA_W-1:0] MODE_UP_RC = 32'h0000_C000;

	always #10 clk = ~clk;

	three_channel_timer_counter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.address    (address),
		.write_data (write_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_data  (read_data),
		.irq        (irq),
		.bad_access (bad_access)
	);

	tc3_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.address    (address),
		.write_data (write_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.read_data  (read_data),
		.irq        (irq),
		.bad_access (bad_access),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic logic [ADDR_W-1:0] reg_at(int ch, logic [OFF_W-1:0] off);
		return {CH_W'(ch), off};
	endfunction

	// Offers one req beat and returns on the edge that takes it. Valid stays
	// high from one beat to the next unless a gap is inserted first.
	task automatic send_beat(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] data);
		int gap;
		gap = 0;
		if (tx_gaps && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= kind;
		address    <= addr;
		write_data <= data;
		do @(posedge clk); while (req_stall);
	endtask

	// Receiver: random stall bursts, plus one long hold when asked. The long
	// hold is counted here so the sender keeps pushing beats meanwhile and
	// the block has to back up into req_stall.
	initial begin
		int burst;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_now) begin
				hold_off_now = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 15);
				rsp_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog. The slowest legal run is about 2k beats plus one long hold;
	// this is several times that.
	initial begin
		#(20 * 600000);
		$display("three_channel_timer_counter: mismatch");
		$finish;
	end

	initial begin
		int               sel;
		int               ch;
		logic [OFF_W-1:0] off;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;

		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		req_type   <= REQ_READ;
		address    <= '0;
		write_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: reset values, write-only/read-only rules, bad access
		send_beat(REQ_READ,  reg_at(0, OFF_CV),  '0);            // stopped clock reads 0
		send_beat(REQ_READ,  reg_at(0, OFF_CCR), '0);            // write-only marker
		send_beat(REQ_READ,  reg_at(1, OFF_IER), '0);
		send_beat(REQ_READ,  reg_at(2, OFF_IDR), '0);
		send_beat(REQ_WRITE, reg_at(0, OFF_CMR), 32'h0000_0000); // capture mode: flagged
		send_beat(REQ_READ,  reg_at(0, OFF_CMR), '0);            // but still stored
		send_beat(REQ_WRITE, reg_at(0, OFF_RC),  32'hFFFF_FFFF); // no period change
		send_beat(REQ_READ,  reg_at(0, OFF_RC),  '0);
		send_beat(REQ_WRITE, reg_at(0, OFF_CMR), 32'hFFFF_FFFF); // wave, WAVSEL 3
		send_beat(REQ_WRITE, reg_at(1, OFF_CCR), 32'h0000_0003); // enable+disable: stays off
		send_beat(REQ_READ,  reg_at(1, OFF_SR),  '0);
		send_beat(REQ_WRITE, reg_at(1, OFF_IER), 32'hFFFF_FFFF);
		send_beat(REQ_WRITE, reg_at(1, OFF_IDR), 32'h0000_FFFF);
		send_beat(REQ_READ,  reg_at(1, OFF_IMR), '0);
		send_beat(REQ_WRITE, reg_at(2, OFF_RA),  32'hFFFF_FFFF);
		send_beat(REQ_WRITE, reg_at(2, OFF_RB),  32'h0000_0000);
		send_beat(REQ_READ,  reg_at(2, OFF_RA),  '0);
		send_beat(REQ_READ,  reg_at(2, OFF_RB),  '0);
		send_beat(REQ_READ,  9'h0C0, '0);                        // channel 3, past channel 2
		send_beat(REQ_WRITE, 9'h0C0, 32'hFFFF_FFFF);             // silently dropped
		send_beat(REQ_READ,  9'h1FF, '0);                        // top of address space
		send_beat(REQ_READ,  reg_at(0, 6'h08), '0);              // hole in the map
		send_beat(REQ_WRITE, reg_at(0, OFF_CV),  32'h1234_5678); // read-only, ignored
		send_beat(REQ_UNDEF, 9'h155, 32'hA5A5_A5A5);
		send_beat(REQ_WRITE, reg_at(2, OFF_CCR), 32'hFFFF_FFFF); // disable wins

		// ---- start every channel with a short period so count reads and
		// period rewrites see running channels
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			send_beat(REQ_WRITE, reg_at(c, OFF_CMR), MODE_UP_RC);
			send_beat(REQ_WRITE, reg_at(c, OFF_RC),  32'(c * 3));
			send_beat(REQ_WRITE, reg_at(c, OFF_CCR), 32'h0000_0005); // start, swtrg ignored
		end
		for (int c = 0; c < NUM_CHANNELS; c++)
			send_beat(REQ_READ, reg_at(c, OFF_SR), '0);

		// ---- random traffic: ticks and register accesses, mostly to real registers,
		// shaped so channels keep short periods and mostly keep running
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == 600)
				hold_off_now = 1'b1;
			if (n == 1200) begin
				// drain everything before going on
				req_valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			if (n == NUM_RANDOM - 300) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end

			sel  = $urandom_range(0, 99);
			ch   = $urandom_range(0, NUM_CHANNELS - 1);
			data = $urandom;
			case ($urandom_range(0, 9))
				0: off = OFF_CCR;
				1: off = OFF_CMR;
				2: off = OFF_CV;
				3: off = OFF_RA;
				4: off = OFF_RB;
				5: off = OFF_RC;
				6: off = OFF_SR;
				7: off = OFF_IER;
				8: off = OFF_IDR;
				default: off = OFF_IMR;
			endcase
			addr = reg_at(ch, off);
			if ($urandom_range(0, 11) == 0)
				addr = ADDR_W'($urandom_range(0, 511));

			if (sel < 35) begin
				send_beat(REQ_TICK, addr, data);
			end else if (sel < 60) begin
				send_beat(REQ_READ, addr, data);
			end else if (sel < 95) begin
				case (off)
					OFF_CMR: begin
						data[WAVE_BIT] = ($urandom_range(0, 7) != 0);
						if ($urandom_range(0, 1))
							data[WAVSEL_HI:WAVSEL_LO] = WAVSEL_UP_RC;
					end
					OFF_RC: begin
						// a big period parks the channel for a long time: keep it rare
						if ($urandom_range(0, 49) != 0)
							data[CNT_W-1:0] = CNT_W'($urandom_range(0, 15));
					end
					OFF_CCR: data[CCR_DIS_BIT] = ($urandom_range(0, 5) == 0);
					default: ;
				endcase
				send_beat(REQ_WRITE, addr, data);
			end else begin
				send_beat(REQ_UNDEF, addr, data);
			end
		end

		// ---- wind down: wait for the last rsp beats, then idle and report
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("three_channel_timer_counter: match");
		else
			$display("three_channel_timer_counter: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/tc3_pkg.sv
hw/rtl/tc3_chan.sv
hw/rtl/three_channel_timer_counter.sv
bench/tc3_checker.sv
bench/testbench.sv
